[rtl/assert_macros.svh]
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/cht_pkg.sv]
// ---------------------------------------------------------------------------
// Chained hash table package
// Shared types, codes and default sizes of the chained hash table.
// ---------------------------------------------------------------------------
package cht_pkg;
   localparam int BUCKETS_DEF = 64;
   localparam int WAYS_DEF    = 8;
   localparam int KEY_W       = 31;
   localparam int VAL_W       = 32;
   localparam int CNT_W       = 7;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_ADDED     = 3'd0,
      ST_FOUND     = 3'd1,
      ST_REMOVED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_MOD, S_FILL, S_SCAN, S_SHIFT, S_DONE
   } state_type;

   // Handshake between the top level and the modulo unit.
   typedef struct packed {
      logic start;
   } mod_ctl_type;
endpackage

[rtl/cht_mod.sv]
// ---------------------------------------------------------------------------
// Chained hash table key modulo unit
// Restoring division of a key by the bucket count, one bit per cycle.
// ---------------------------------------------------------------------------
module cht_mod #(
   parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cht_pkg::mod_ctl_type     ctl,
   input  logic [cht_pkg::KEY_W-1:0] key,
   input  logic [BW:0]              divisor,
   output logic                     done,
   output logic [BW-1:0]            remainder
);
   localparam int KW = cht_pkg::KEY_W;
   localparam int CW = $clog2(KW + 1);

   logic [KW-1:0] key_ff, key_in;
   logic [BW:0]   rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [BW+1:0] trial;

   // One restoring step a cycle, most significant key bit first.
   always_comb begin
      key_in  = key_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, key_ff[KW-1]};
      if (ctl.start) begin
         key_in  = key;
         rem_in  = '0;
         cnt_in  = CW'(KW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         key_in = key_ff << 1;
         if (trial >= {1'b0, divisor}) rem_in = BW'(0) + (BW+1)'(trial - {1'b0, divisor});
         else rem_in = (BW+1)'(trial);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      key_ff <= key_in;
      rem_ff <= rem_in;
   end

   assign done      = busy_ff && (cnt_ff == CW'(1));
   assign remainder = rem_in[BW-1:0];
endmodule

[rtl/chained_hash_table.sv]
// ---------------------------------------------------------------------------
// Chained hash table
// Bounded-bucket hash table with add, search and remove transactions.
// ---------------------------------------------------------------------------
// Usage: drive req_cmd, req_key and req_data_in with start high while busy is
// low; the transaction is taken at that clock edge. Exactly one result per
// transaction appears on rsp_status and rsp_data_out for one cycle, marked by
// rsp_valid; the receiver cannot stall it. busy stays high from acceptance
// through the result cycle.
// Sequence: a bit-serial key modulo (a load step and 31 restoring steps), a
// read of the bucket fill count, then for a search or remove a scan of the
// filled ways in order up to a hit and, for a remove, a shift down of each
// later entry. The result is registered from S_DONE, and the next transaction
// can be taken in the cycle after the result; the modulo unit and the single
// entry memory port set the throughput.
// bucket_count is to be written through csr_we/csr_wdata only while the block is
// idle; the block does not enforce this. 0 acts as 1, above BUCKETS as BUCKETS.
// Reset: synchronous, active high; bucket_count returns to 64 and every fill
// count is cleared by valid bits at once, so no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module chained_hash_table #(
   parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
   parameter int WAYS    = cht_pkg::WAYS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_cmd,
   input  logic [cht_pkg::KEY_W-1:0]         req_key,
   input  logic signed [cht_pkg::VAL_W-1:0]  req_data_in,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_status,
   output logic signed [cht_pkg::VAL_W-1:0]  rsp_data_out,
   input  logic                              csr_we,
   input  logic [cht_pkg::CNT_W-1:0]         csr_wdata
);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FW = $clog2(WAYS + 1);
   localparam int AW = BW + WW;
   localparam int DEPTH = BUCKETS << WW;
   localparam int KW = cht_pkg::KEY_W;
   localparam int VW = cht_pkg::VAL_W;
   localparam int EW = KW + VW;

   cht_pkg::state_type state_ff, state_in;
   logic [cht_pkg::CNT_W-1:0] count_ff;
   logic [1:0]     cmd_ff;
   logic [KW-1:0]  key_ff;
   logic [VW-1:0]  val_ff;
   logic [BW-1:0]  bkt_ff, bkt_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic [FW-1:0]  way_ff, way_in;
   logic           rd_pend_ff, rd_pend_in;
   logic [2:0]     st_ff, st_in;
   logic [VW-1:0]  dout_ff, dout_in;
   logic           rv_ff, rv_in;
   logic           accept;

   // Entry memory holds key and value; fill counts in a small memory with valid bits.
   logic [EW-1:0]  ent_mem [DEPTH];
   logic [EW-1:0]  ent_q;
   logic           ent_we, ent_re;
   logic [AW-1:0]  ent_waddr, ent_raddr;
   logic [EW-1:0]  ent_wdata;
   logic [FW-1:0]  fill_mem [BUCKETS];
   logic [BUCKETS-1:0] fvalid_ff;
   logic [FW-1:0]  fill_q;
   logic           fill_we;
   logic [FW-1:0]  fill_wdata;

   cht_pkg::mod_ctl_type mctl;
   logic           mdone;
   logic [BW-1:0]  mrem;
   logic [BW:0]    divisor;

   // A transaction is taken only while the block is not busy.
   assign accept = start && !busy;

   // Clamp the configured count into 1..BUCKETS.
   always_comb begin
      if (count_ff == '0) divisor = (BW+1)'(1);
      else if ({25'd0, count_ff} > 32'(BUCKETS)) divisor = (BW+1)'(BUCKETS);
      else divisor = (BW+1)'(count_ff);
   end

   cht_mod #(.BUCKETS(BUCKETS)) u_mod (
      .clock(clock), .reset(reset), .ctl(mctl), .key(key_ff),
      .divisor(divisor), .done(mdone), .remainder(mrem)
   );

   // Memories: registered reads.
   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
      if (ent_re) ent_q <= ent_mem[ent_raddr];
      if (fill_we) fill_mem[bkt_ff] <= fill_wdata;
      fill_q <= fill_mem[bkt_in];
   end

   // Sequencer: modulo, fill read, add write or scan, then shift for a remove.
   always_comb begin
      state_in   = state_ff;
      bkt_in     = bkt_ff;
      fill_in    = fill_ff;
      way_in     = way_ff;
      rd_pend_in = 1'b0;
      st_in      = st_ff;
      dout_in    = dout_ff;
      rv_in      = 1'b0;
      mctl.start = 1'b0;
      ent_we     = 1'b0;
      ent_re     = 1'b0;
      ent_waddr  = {bkt_ff, way_ff[WW-1:0]};
      ent_raddr  = {bkt_ff, way_ff[WW-1:0]};
      ent_wdata  = {key_ff, val_ff};
      fill_we    = 1'b0;
      fill_wdata = fill_ff;
      unique case (state_ff)
         cht_pkg::S_IDLE: begin
            if (accept) state_in = cht_pkg::S_MOD;
         end
         cht_pkg::S_MOD: begin
            if (!rd_pend_ff) begin
               mctl.start = 1'b1;
               rd_pend_in = 1'b1;
            end else if (mdone) begin
               bkt_in   = mrem;
               state_in = cht_pkg::S_FILL;
            end else begin
               rd_pend_in = 1'b1;
            end
         end
         cht_pkg::S_FILL: begin
            fill_in = fvalid_ff[bkt_ff] ? fill_q : '0;
            way_in  = '0;
            st_in   = cht_pkg::ST_NOT_FOUND;
            dout_in = '0;
            if (cmd_ff == cht_pkg::CMD_ADD) begin
               if (fill_in >= FW'(WAYS)) begin
                  st_in    = cht_pkg::ST_FULL;
                  state_in = cht_pkg::S_DONE;
               end else begin
                  ent_we     = 1'b1;
                  ent_waddr  = {bkt_ff, fill_in[WW-1:0]};
                  fill_we    = 1'b1;
                  fill_wdata = fill_in + 1'b1;
                  st_in      = cht_pkg::ST_ADDED;
                  state_in   = cht_pkg::S_DONE;
               end
            end else if ((cmd_ff == cht_pkg::CMD_SEARCH || cmd_ff == cht_pkg::CMD_REMOVE)
                         && fill_in != '0) begin
               ent_re     = 1'b1;
               ent_raddr  = {bkt_ff, WW'(0)};
               rd_pend_in = 1'b1;
               state_in   = cht_pkg::S_SCAN;
            end else begin
               state_in = cht_pkg::S_DONE;
            end
         end
         cht_pkg::S_SCAN: begin
            if (ent_q[EW-1:VW] == key_ff) begin
               if (cmd_ff == cht_pkg::CMD_SEARCH) begin
                  st_in    = cht_pkg::ST_FOUND;
                  dout_in  = ent_q[VW-1:0];
                  state_in = cht_pkg::S_DONE;
               end else begin
                  st_in      = cht_pkg::ST_REMOVED;
                  fill_we    = 1'b1;
                  fill_wdata = fill_ff - 1'b1;
                  if (way_ff + 1'b1 < fill_ff) begin
                     ent_re    = 1'b1;
                     ent_raddr = {bkt_ff, WW'(way_ff + 1'b1)};
                     state_in  = cht_pkg::S_SHIFT;
                  end else begin
                     state_in = cht_pkg::S_DONE;
                  end
               end
            end else if (way_ff + 1'b1 < fill_ff) begin
               way_in    = way_ff + 1'b1;
               ent_re    = 1'b1;
               ent_raddr = {bkt_ff, WW'(way_in)};
            end else begin
               state_in = cht_pkg::S_DONE;
            end
         end
         cht_pkg::S_SHIFT: begin
            // Entry way+1 has been read: store it at way, fetch the next.
            ent_we    = 1'b1;
            ent_waddr = {bkt_ff, way_ff[WW-1:0]};
            ent_wdata = ent_q;
            way_in    = way_ff + 1'b1;
            if (way_in + 1'b1 < fill_ff) begin
               ent_re    = 1'b1;
               ent_raddr = {bkt_ff, WW'(way_in + 1'b1)};
            end else begin
               state_in = cht_pkg::S_DONE;
            end
         end
         cht_pkg::S_DONE: begin
            rv_in    = 1'b1;
            state_in = cht_pkg::S_IDLE;
         end
         default: state_in = cht_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= cht_pkg::S_IDLE;
         count_ff   <= cht_pkg::CNT_W'(64);
         fvalid_ff  <= '0;
         rd_pend_ff <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
         rv_ff      <= rv_in;
         if (csr_we) count_ff <= csr_wdata;
         if (fill_we) fvalid_ff[bkt_ff] <= 1'b1;
      end
      if (state_ff == cht_pkg::S_IDLE && accept) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key;
         val_ff <= req_data_in;
      end
      bkt_ff  <= bkt_in;
      fill_ff <= fill_in;
      way_ff  <= way_in;
      st_ff   <= st_in;
      dout_ff <= dout_in;
   end

   assign busy         = (state_ff != cht_pkg::S_IDLE) || rv_ff;
   assign rsp_valid    = rv_ff;
   assign rsp_status   = st_ff;
   assign rsp_data_out = dout_ff;

   // Assertions.
   `ASSERT_NEXT(a_one_result, clock, reset, rv_ff, !rv_ff, "result strobe held twice")
   `ASSERT_IMPL(a_data_zero, clock, reset, rv_ff && st_ff != cht_pkg::ST_FOUND,
                dout_ff == '0, "data_out non-zero without a hit")
   `ASSERT_IMPL(a_fill_bound, clock, reset, fill_we, fill_wdata <= FW'(WAYS),
                "fill count above ways")
endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chained hash table testbench
// Drives add, search and remove transactions with random gaps, predicts
// every result from its own copy of the buckets and checks each one.
// ---------------------------------------------------------------------------

// Expected results of the hash table, kept in acceptance order.
class hash_table_scoreboard;
   localparam int NBKT = cht_pkg::BUCKETS_DEF;
   localparam int NWAY = cht_pkg::WAYS_DEF;

   logic [30:0] bkt_keys [NBKT][NWAY];
   logic [31:0] bkt_vals [NBKT][NWAY];
   int          bkt_fill [NBKT];
   int          divisor;
   logic [2:0]  exp_status [$];
   logic [31:0] exp_data [$];
   int          mismatches;
   int          checked;
   int          adds_full;
   int          removes_hit;

   function void clear_table();
      foreach (bkt_fill[i]) bkt_fill[i] = 0;
      divisor = 64;
      mismatches = 0;
      checked = 0;
      adds_full = 0;
      removes_hit = 0;
   endfunction

   function void set_divisor(logic [6:0] v);
      divisor = v;
   endfunction

   // Oldest way holding the key, or -1 when the bucket lacks it.
   function int oldest_way(int b, logic [30:0] k);
      for (int w = 0; w < bkt_fill[b]; w++)
         if (bkt_keys[b][w] == k) return w;
      return -1;
   endfunction

   // Note an accepted transaction and predict its result.
   function void note_request(cht_pkg::cmd_type c, logic [30:0] k, logic [31:0] d);
      int n;
      int b;
      int w;
      cht_pkg::status_type st;
      logic [31:0] dout;
      n = (divisor == 0) ? 1 : (divisor > NBKT ? NBKT : divisor);
      b = k % n;
      st = cht_pkg::ST_NOT_FOUND;
      dout = '0;
      case (c)
         cht_pkg::CMD_ADD: begin
            if (bkt_fill[b] >= NWAY) begin
               st = cht_pkg::ST_FULL;
               adds_full++;
            end else begin
               bkt_keys[b][bkt_fill[b]] = k;
               bkt_vals[b][bkt_fill[b]] = d;
               bkt_fill[b]++;
               st = cht_pkg::ST_ADDED;
            end
         end
         cht_pkg::CMD_SEARCH: begin
            w = oldest_way(b, k);
            if (w >= 0) begin
               st = cht_pkg::ST_FOUND;
               dout = bkt_vals[b][w];
            end
         end
         cht_pkg::CMD_REMOVE: begin
            w = oldest_way(b, k);
            if (w >= 0) begin
               for (int i = w; i + 1 < bkt_fill[b]; i++) begin
                  bkt_keys[b][i] = bkt_keys[b][i+1];
                  bkt_vals[b][i] = bkt_vals[b][i+1];
               end
               bkt_fill[b]--;
               st = cht_pkg::ST_REMOVED;
               removes_hit++;
            end
         end
         default: ;
      endcase
      exp_status.push_back(st);
      exp_data.push_back(dout);
   endfunction

   // Compare one result with the oldest expectation.
   function void check_result(logic [2:0] st, logic [31:0] d);
      logic [2:0]  es;
      logic [31:0] ed;
      if (exp_status.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: status %0d data %h", st, d);
         return;
      end
      es = exp_status.pop_front();
      ed = exp_data.pop_front();
      checked++;
      if (st !== es || d !== ed) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: status exp %0d got %0d, data exp %h got %h",
                     es, st, ed, d);
      end
   endfunction
endclass

module testbench;
   localparam int WATCHDOG = 4000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_cmd;
   logic [cht_pkg::KEY_W-1:0]  req_key;
   logic signed [cht_pkg::VAL_W-1:0] req_data_in;
   logic              rsp_valid;
   logic [2:0]        rsp_status;
   logic signed [cht_pkg::VAL_W-1:0] rsp_data_out;
   logic              csr_we;
   logic [cht_pkg::CNT_W-1:0]  csr_wdata;

   hash_table_scoreboard sb;
   int  idle_cycles;
   bit  gaps_on;
   int  sent;
   logic [30:0] recent_keys [$];

   chained_hash_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_key(req_key), .req_data_in(req_data_in),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_data_out(rsp_data_out),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Check results and count cycles without progress.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_status, rsp_data_out);
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG) begin
            $display("timeout with %0d results outstanding", sb.exp_status.size());
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   // Present one transaction and wait until it is taken; start stays high so
   // that a following transaction can be presented without a gap.
   task automatic send(cht_pkg::cmd_type c, logic [30:0] k, logic [31:0] d);
      int gap;
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 9);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= c;
      req_key <= k;
      req_data_in <= d;
      do @(posedge clock); while (busy);
      sb.note_request(c, k, d);
      sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (sb.exp_status.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_bucket_count(logic [6:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_divisor(v);
   endtask

   // Key picked so that searches and removes often hit stored entries.
   function automatic logic [30:0] pick_key(int span);
      if (recent_keys.size() != 0 && $urandom_range(0, 2) != 0)
         return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      return (span == 0) ? 31'($urandom) : 31'($urandom_range(0, span));
   endfunction

   task automatic random_phase(int count, int span);
      cht_pkg::cmd_type c;
      logic [30:0] k;
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         c = (r < 40) ? cht_pkg::CMD_ADD :
             (r < 70) ? cht_pkg::CMD_SEARCH :
             (r < 97) ? cht_pkg::CMD_REMOVE : cht_pkg::CMD_NONE;
         k = pick_key(span);
         if (c == cht_pkg::CMD_ADD) begin
            recent_keys.push_back(k);
            if (recent_keys.size() > 40) void'(recent_keys.pop_front());
         end
         send(c, k, $urandom);
      end
   endtask

   initial begin
      sb = new();
      sb.clear_table();
      reset = 1'b1;
      start = 1'b0;
      req_cmd = cht_pkg::CMD_ADD;
      req_key = '0;
      req_data_in = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      idle_cycles = 0;
      gaps_on = 1'b0;
      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, duplicates, a full bucket and the unused command.
      send(cht_pkg::CMD_ADD, 31'h7fffffff, 32'h80000000);
      send(cht_pkg::CMD_ADD, 31'h0, 32'h7fffffff);
      send(cht_pkg::CMD_SEARCH, 31'h7fffffff, 32'hffffffff);
      send(cht_pkg::CMD_ADD, 31'd64, 32'hffffffff);
      send(cht_pkg::CMD_ADD, 31'd64, 32'h00000001);
      send(cht_pkg::CMD_SEARCH, 31'd64, 32'h0);
      send(cht_pkg::CMD_REMOVE, 31'd64, 32'h0);
      send(cht_pkg::CMD_SEARCH, 31'd64, 32'h0);
      for (int i = 0; i < 7; i++) send(cht_pkg::CMD_ADD, 31'(5 + 64 * i), 32'(i));
      send(cht_pkg::CMD_ADD, 31'd5, 32'hdeadbeef);
      send(cht_pkg::CMD_ADD, 31'd517, 32'h12345678);
      send(cht_pkg::CMD_REMOVE, 31'd133, 32'h0);
      send(cht_pkg::CMD_SEARCH, 31'd197, 32'h0);
      send(cht_pkg::CMD_REMOVE, 31'd999, 32'h0);
      send(cht_pkg::CMD_NONE, 31'd0, 32'h55555555);

      // Random phases over several bucket counts, extremes included.
      gaps_on = 1'b1;
      random_phase(300, 0);
      write_bucket_count(7'd1);
      random_phase(200, 60);
      write_bucket_count(7'd0);
      random_phase(100, 40);
      write_bucket_count(7'd127);
      random_phase(250, 0);
      write_bucket_count(7'd3);
      random_phase(250, 200);
      write_bucket_count(7'd64);
      random_phase(250, 0);
      gaps_on = 1'b0;
      write_bucket_count(7'd17);
      random_phase(230, 500);

      wait_drained();
      $display("covered %0d transactions, %0d results checked, %0d full adds, %0d hits removed",
               sent, sb.checked, sb.adds_full, sb.removes_hit);
      if (sb.mismatches == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end
endmodule
